// File: hw/rtl/z2x_pkg.sv
// Shared constants and types for the 2x bilinear zoom block.
`timescale 1ns / 1ps
`default_nettype none

package z2x_pkg;

    // Line buffer depth; a power of two, so the window column indexes it by truncation.
    localparam int MAX_ROW_PIXELS = 1024;
    localparam int ROW_AW         = $clog2(MAX_ROW_PIXELS);

    localparam int PIX_W   = 8;
    localparam int COORD_W = 11;
    localparam int COL_W   = 10;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_WINDOW_TOP    = 3'd1,
        CFG_WINDOW_LEFT   = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_WINDOW_WIDTH  = 3'd4
    } t_cfg_idx;

    // Window position of an incoming pixel, as found by the front end.
    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] r;
        logic [COL_W-1:0]   c;
    } t_win;

    // One window pixel travelling to the result sequencer.
    typedef struct packed {
        logic [COORD_W-1:0] r;
        logic [COL_W-1:0]   c;
        logic [PIX_W-1:0]   p;
    } t_px;

endpackage

`default_nettype wire

// File: hw/rtl/zoom2x_interpolate.sv
// Top level of the streaming 2x bilinear enlargement of a gray image window.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake                   Payload
//  ------    ---------  --------------------------  -------------------------------------
//  input     in         i_in_valid / o_in_ready     i_pixel_in, i_image_start
//  result    out        o_out_valid / i_out_ready   o_out_row, o_out_col, o_pixel_out, o_last
//  config    in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
//  A window pixel gives one to four result beats, one per cycle while the receiver is ready,
//  so the result sequencer sets the rate. A pixel outside the window only moves the source position on.
//  The line buffer is read and written in the accepting cycle; the first result beat is
//  offered once the pixel has moved from the averaging stage into the sequencer.
//  Reset is synchronous, active low; the line buffer is not cleared. A stalled result side
//  holds one pixel in the sequencer and one in the averaging stage, then stalls the input.

module zoom2x_interpolate import z2x_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [PIX_W-1:0]     i_pixel_in,
    input  wire logic                 i_image_start,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [COORD_W-1:0]        o_out_row,
    output logic [COORD_W-1:0]        o_out_col,
    output logic [PIX_W-1:0]          o_pixel_out,
    output logic                      o_last,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [CFG_W-1:0] r_source_width;
    logic [COL_W-1:0] r_window_top;
    logic [COL_W-1:0] r_window_left;
    logic [CFG_W-1:0] r_window_height;
    logic [CFG_W-1:0] r_window_width;

    logic             in_accept;
    logic             buf_access;
    t_win             win;
    t_px              px;
    logic [PIX_W-1:0] above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= 11'd1024;
            r_window_top    <= '0;
            r_window_left   <= '0;
            r_window_height <= 11'd1;
            r_window_width  <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg_data;
                CFG_WINDOW_TOP:    r_window_top    <= i_cfg_data[COL_W-1:0];
                CFG_WINDOW_LEFT:   r_window_left   <= i_cfg_data[COL_W-1:0];
                CFG_WINDOW_HEIGHT: r_window_height <= i_cfg_data;
                CFG_WINDOW_WIDTH:  r_window_width  <= i_cfg_data;
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    assign in_accept = i_in_valid && o_in_ready;

    z2x_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_image_start   (i_image_start),
        .i_source_width  (r_source_width),
        .i_window_top    (r_window_top),
        .i_window_left   (r_window_left),
        .i_window_height (r_window_height),
        .i_window_width  (r_window_width),
        .o_win           (win)
    );

    // The window pixel's line buffer entry is read and overwritten in the same cycle; the
    // RAM returns the old value, i.e. the pixel above from the previous window row.
    // The window column is always below the buffer depth, so it indexes directly.
    assign buf_access = in_accept && win.hit;

    z2x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_ROW_PIXELS)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_en    (buf_access),
        .i_we    (buf_access),
        .i_addr  (ROW_AW'(win.c)),
        .i_wdata (i_pixel_in),
        .o_rdata (above)
    );

    always_comb begin
        px.r = win.r;
        px.c = win.c;
        px.p = i_pixel_in;
    end

    // The read data stays put until the next access, which cannot happen before the
    // averaging stage has handed its pixel on.
    z2x_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (buf_access),
        .i_px         (px),
        .i_above      (above),
        .o_take_ready (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_pixel_out  (o_pixel_out),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// File: hw/rtl/z2x_ram.sv
// Generic single-port RAM with registered, read-first read data.
`timescale 1ns / 1ps
`default_nettype none

module z2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/z2x_front.sv
// Source position tracking and window test for incoming pixels.
`timescale 1ns / 1ps
`default_nettype none

module z2x_front import z2x_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_image_start,
    input  wire logic [CFG_W-1:0]   i_source_width,
    input  wire logic [COL_W-1:0]   i_window_top,
    input  wire logic [COL_W-1:0]   i_window_left,
    input  wire logic [CFG_W-1:0]   i_window_height,
    input  wire logic [CFG_W-1:0]   i_window_width,
    output t_win                    o_win
);

    logic [COORD_W-1:0] r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [COORD_W-1:0] eff_row;
    logic [COL_W-1:0]   eff_col;
    logic [COORD_W:0]   row_lim;
    logic [COORD_W:0]   col_lim;
    logic               in_rows;
    logic               in_cols;
    logic               row_end;

    always_comb begin
        eff_row = i_image_start ? '0 : r_row;
        eff_col = i_image_start ? '0 : r_col;

        row_lim = {2'b00, i_window_top} + {1'b0, i_window_height};
        col_lim = {2'b00, i_window_left} + {1'b0, i_window_width};
        in_rows = (eff_row >= {1'b0, i_window_top}) && ({1'b0, eff_row} < row_lim);
        in_cols = (eff_col >= i_window_left) && ({2'b00, eff_col} < col_lim);

        o_win.hit = in_rows && in_cols;
        o_win.r   = eff_row - {1'b0, i_window_top};
        o_win.c   = eff_col - i_window_left;

        // A width of zero behaves as one; the column never passes 1023.
        row_end = (&eff_col) || (({1'b0, eff_col} + 11'd1) >= i_source_width);
        if (row_end) begin
            n_col = '0;
            n_row = (&eff_row) ? eff_row : eff_row + 11'd1;
        end else begin
            n_col = eff_col + 10'd1;
            n_row = eff_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/z2x_emit.sv
// Neighbour averaging stage and result sequencer, one result beat per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module z2x_emit import z2x_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  t_px                     i_px,
    input  wire logic [PIX_W-1:0]   i_above,
    output logic                    o_take_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [COORD_W-1:0]      o_out_row,
    output logic [COORD_W-1:0]      o_out_col,
    output logic [PIX_W-1:0]        o_pixel_out,
    output logic                    o_last
);

    typedef enum logic [3:0] {
        PH_ORIG  = 4'b0001,
        PH_HORIZ = 4'b0010,
        PH_VERT  = 4'b0100,
        PH_DIAG  = 4'b1000
    } t_phase;

    // Stage holding a window pixel while its line buffer read completes.
    logic               r_s1_v;
    t_px                r_s1;
    logic [PIX_W-1:0]   r_left;
    logic [PIX_W-1:0]   r_upleft;

    // Result sequencer registers.
    logic               r_em_v;
    t_phase             r_ph;
    t_phase             n_ph;
    logic               r_has_c;
    logic               r_has_r;
    logic [COORD_W-1:0] r_row2;
    logic [COORD_W-1:0] r_col2;
    logic [PIX_W-1:0]   r_pix_orig;
    logic [PIX_W-1:0]   r_pix_horiz;
    logic [PIX_W-1:0]   r_pix_vert;
    logic [PIX_W-1:0]   r_pix_diag;

    logic               em_take;
    logic               em_last;
    logic               s1_move;
    logic [PIX_W-1:0]   ph_pix;
    logic               ph_up;
    logic               ph_back;
    logic [PIX_W:0]     sum_h;
    logic [PIX_W:0]     sum_v;
    logic [PIX_W+1:0]   sum_d;

    always_comb begin
        em_last = 1'b1;
        n_ph    = r_ph;
        ph_pix  = r_pix_orig;
        ph_up   = 1'b0;
        ph_back = 1'b0;
        unique case (r_ph)
            PH_ORIG: begin
                if (r_has_c) begin
                    em_last = 1'b0;
                    n_ph    = PH_HORIZ;
                end else if (r_has_r) begin
                    em_last = 1'b0;
                    n_ph    = PH_VERT;
                end
            end
            PH_HORIZ: begin
                ph_pix  = r_pix_horiz;
                ph_back = 1'b1;
                if (r_has_r) begin
                    em_last = 1'b0;
                    n_ph    = PH_VERT;
                end
            end
            PH_VERT: begin
                ph_pix = r_pix_vert;
                ph_up  = 1'b1;
                if (r_has_c) begin
                    em_last = 1'b0;
                    n_ph    = PH_DIAG;
                end
            end
            PH_DIAG: begin
                ph_pix  = r_pix_diag;
                ph_up   = 1'b1;
                ph_back = 1'b1;
            end
            default: begin
                em_last = 1'b1;
            end
        endcase

        em_take      = r_em_v && i_out_ready;
        s1_move      = r_s1_v && (!r_em_v || (em_take && em_last));
        o_take_ready = !r_s1_v || s1_move;

        sum_h = {1'b0, r_left} + {1'b0, r_s1.p} + 9'd1;
        sum_v = {1'b0, i_above} + {1'b0, r_s1.p} + 9'd1;
        sum_d = {2'b00, r_upleft} + {2'b00, r_left} + {2'b00, i_above}
              + {2'b00, r_s1.p} + 10'd2;

        o_out_valid = r_em_v;
        o_out_row   = ph_up ? r_row2 - 11'd1 : r_row2;
        o_out_col   = ph_back ? r_col2 - 11'd1 : r_col2;
        o_pixel_out = ph_pix;
        o_last      = em_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_left   <= '0;
            r_upleft <= '0;
            r_em_v   <= 1'b0;
            r_ph     <= PH_ORIG;
        end else begin
            if (i_load) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end

            if (s1_move) begin
                r_left   <= r_s1.p;
                r_upleft <= i_above;
                r_em_v   <= 1'b1;
                r_ph     <= PH_ORIG;
            end else if (em_take) begin
                if (em_last) begin
                    r_em_v <= 1'b0;
                end else begin
                    r_ph <= n_ph;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_px;
        end
        if (s1_move) begin
            r_has_c     <= (r_s1.c != '0);
            r_has_r     <= (r_s1.r != '0);
            r_row2      <= {r_s1.r[COORD_W-2:0], 1'b0};
            r_col2      <= {r_s1.c, 1'b0};
            r_pix_orig  <= r_s1.p;
            r_pix_horiz <= sum_h[PIX_W:1];
            r_pix_vert  <= sum_v[PIX_W:1];
            r_pix_diag  <= sum_d[PIX_W+1:2];
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the 2x bilinear window enlargement block.
`timescale 1ns / 1ps

module testbench;
    import z2x_pkg::*;

    // A watchdog ends the run if no beat, and no register write, happens for this many cycles.
    // The slowest legal pixel needs four result beats, each behind the longest receiver
    // stall, plus the longest sender gap; the idle pause between window settings is far
    // shorter still.
    localparam int QUIET_LIMIT = 2000;

    // Number of source pixels the whole run offers.
    localparam int unsigned ITEMS = 220;

    // One source pixel waiting to be offered on the input channel.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             first;
    } t_feed_px;

    // One pixel of the enlarged image, as the block should deliver it.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   value;
        logic               last;
    } t_zoom_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Input channel, driven at the falling edge.
    logic             in_valid = 1'b0;
    logic [PIX_W-1:0] in_pixel = '0;
    logic             in_start = 1'b0;
    logic             o_in_ready;

    // Result channel.
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] o_out_row;
    logic [COORD_W-1:0] o_out_col;
    logic [PIX_W-1:0]   o_pixel_out;
    logic               o_last;

    // Register write port.
    logic             cfg_we   = 1'b0;
    t_cfg_idx         cfg_idx  = CFG_SOURCE_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    // Stimulus and expectations.
    t_feed_px   pixel_feed[$];
    t_zoom_beat zoom_due[$];
    t_feed_px   next_px;

    // The predictor's own copy of the registers, at their reset values.
    int unsigned cfg_src_width = 1024;
    int unsigned cfg_top       = 0;
    int unsigned cfg_left      = 0;
    int unsigned cfg_height    = 1;
    int unsigned cfg_width     = 1;

    // The predictor's own copy of the state: the previous window row, the pixel to the left,
    // the line buffer entry above that left pixel, and the position of the next source pixel.
    bit [PIX_W-1:0] line_buf [MAX_ROW_PIXELS];
    bit [PIX_W-1:0] left_px   = '0;
    bit [PIX_W-1:0] upleft_px = '0;
    int unsigned    src_row   = 0;
    int unsigned    src_col   = 0;

    // Handshake bookkeeping and idling control.
    logic        in_taken  = 1'b0;
    logic        steady    = 1'b0;
    int unsigned gap_left  = 0;
    int unsigned hold_left = 0;
    int unsigned cyc       = 0;
    int          quiet     = 0;

    // Run statistics.
    int unsigned fed_total     = 0;
    int unsigned win_pixels    = 0;
    int unsigned dropped       = 0;
    int unsigned beats_checked = 0;
    int unsigned settings_used = 0;
    int unsigned mismatches    = 0;

    zoom2x_interpolate u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_in    (in_pixel),
        .i_image_start (in_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_pixel_out   (o_pixel_out),
        .o_last        (o_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pause lengths for both sides: mostly none or short, now and then long. During a
    // steady stretch neither side pauses at all, so the block also sees full rate.
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_zoom_beat mk_beat(input int unsigned row, col, val);
        t_zoom_beat b;
        // The coordinates wrap at 2048, which the truncation to eleven bits gives.
        b.row   = row[COORD_W-1:0];
        b.col   = col[COORD_W-1:0];
        b.value = val[PIX_W-1:0];
        b.last  = 1'b0;
        return b;
    endfunction

    // Works out the enlarged-image pixels that one accepted source pixel gives, queues them
    // in order, and moves the source position on.
    task automatic zoom_predict(input logic [PIX_W-1:0] p, input logic first);
        int unsigned r, c, above, lft, n;
        t_zoom_beat  b [4];
        n = 0;
        if (first) begin
            src_row = 0;
            src_col = 0;
        end
        if (src_row >= cfg_top && src_row < cfg_top + cfg_height &&
            src_col >= cfg_left && src_col < cfg_left + cfg_width) begin
            r     = src_row - cfg_top;
            c     = src_col - cfg_left;
            above = line_buf[c % MAX_ROW_PIXELS];
            lft   = left_px;
            b[n] = mk_beat(2 * r, 2 * c, p);
            n++;
            if (c > 0) begin
                b[n] = mk_beat(2 * r, 2 * c - 1, (lft + p + 1) >> 1);
                n++;
            end
            if (r > 0) begin
                b[n] = mk_beat(2 * r - 1, 2 * c, (above + p + 1) >> 1);
                n++;
            end
            if (r > 0 && c > 0) begin
                b[n] = mk_beat(2 * r - 1, 2 * c - 1, (upleft_px + lft + above + p + 2) >> 2);
                n++;
            end
            b[n - 1].last = 1'b1;
            for (int k = 0; k < n; k++)
                zoom_due.push_back(b[k]);
            upleft_px = above;
            line_buf[c % MAX_ROW_PIXELS] = p;
            left_px = p;
            win_pixels++;
        end else begin
            dropped++;
        end
        // The column wraps at the end of a source row or at 1023, whichever comes first;
        // a width of zero behaves as one. The row count sticks at 2047.
        if (src_col >= 1023 || src_col + 1 >= cfg_src_width) begin
            src_col = 0;
            if (src_row < 2047)
                src_row++;
        end else begin
            src_col++;
        end
    endtask

    // Monitor: predicts on every accepted pixel, checks every accepted result beat, and keeps
    // the watchdog. The outputs are read here before the block's own updates at this edge.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 64 == 0)
            steady <= ($urandom_range(0, 3) == 0);
        in_taken <= in_valid && o_in_ready && i_rst_n;

        if (i_rst_n && in_valid && o_in_ready)
            zoom_predict(in_pixel, in_start);

        if (i_rst_n && o_out_valid && out_ready) begin
            beats_checked++;
            if (zoom_due.size() == 0) begin
                $error("result beat with nothing expected: row %0d col %0d value %0d",
                       o_out_row, o_out_col, o_pixel_out);
                mismatches++;
            end else begin
                if (o_out_row !== zoom_due[0].row) begin
                    $error("out_row: expected %0d, got %0d", zoom_due[0].row, o_out_row);
                    mismatches++;
                end
                if (o_out_col !== zoom_due[0].col) begin
                    $error("out_col: expected %0d, got %0d", zoom_due[0].col, o_out_col);
                    mismatches++;
                end
                if (o_pixel_out !== zoom_due[0].value) begin
                    $error("pixel_out: expected %0d, got %0d", zoom_due[0].value, o_pixel_out);
                    mismatches++;
                end
                if (o_last !== zoom_due[0].last) begin
                    $error("last: expected %0d, got %0d", zoom_due[0].last, o_last);
                    mismatches++;
                end
                void'(zoom_due.pop_front());
            end
        end

        if (!i_rst_n || cfg_we || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $error("no beat for %0d cycles, %0d results still awaited", quiet, zoom_due.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Pixel driver: once the beat on the bus has gone, it waits out a random gap and then
    // offers the next pending pixel, holding it until the block takes it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pixel_feed.size() != 0) begin
                next_px  = pixel_feed.pop_front();
                in_valid <= 1'b1;
                in_pixel <= next_px.pix;
                in_start <= next_px.first;
                gap_left <= pick_pause();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready for a cycle, then possibly stalled for a random while.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= 1'b1;
            hold_left <= pick_pause();
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_W-1:0];
        case (idx)
            CFG_SOURCE_WIDTH:  cfg_src_width = val % 2048;
            CFG_WINDOW_TOP:    cfg_top       = val % 1024;
            CFG_WINDOW_LEFT:   cfg_left      = val % 1024;
            CFG_WINDOW_HEIGHT: cfg_height    = val % 2048;
            CFG_WINDOW_WIDTH:  cfg_width     = val % 2048;
            default: ;
        endcase
    endtask

    // Writes the whole window setting. Only called while the block is idle.
    task automatic set_window(input int unsigned sw, tp, lf, ht, wd);
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_WINDOW_TOP, tp);
        write_reg(CFG_WINDOW_LEFT, lf);
        write_reg(CFG_WINDOW_HEIGHT, ht);
        write_reg(CFG_WINDOW_WIDTH, wd);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
        @(posedge i_clk);
    endtask

    task automatic feed_pixel(input int unsigned p, input bit first);
        t_feed_px f;
        f.pix   = p[PIX_W-1:0];
        f.first = first;
        pixel_feed.push_back(f);
        fed_total++;
    endtask

    // Queues n pixels of an image, flagging the first. Style 0 gives random grey values,
    // style 1 values at or next to black and white, style 2 random values with stray
    // image starts that cut the image short.
    task automatic queue_image(input int unsigned n, input int unsigned style);
        int unsigned p;
        for (int unsigned k = 0; k < n; k++) begin
            if (style == 1)
                p = $urandom_range(0, 1) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1);
            else
                p = $urandom_range(0, 255);
            feed_pixel(p, k == 0 || (style == 2 && $urandom_range(0, 19) == 0));
        end
    endtask

    // Waits until every pixel has gone in and every expected result has come out, then lets
    // the block finish any dropped pixel still in flight.
    task automatic settle();
        while (pixel_feed.size() != 0 || in_valid || zoom_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sw, tp, lf, ht, wd, rows, n, style;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A whole 4x3 image as the window: both edges of the value range side by side, so
        // that every kind of average is seen with carries and with half-way rounding.
        set_window(4, 0, 0, 3, 4);
        feed_pixel(0, 1);   feed_pixel(255, 0); feed_pixel(1, 0);   feed_pixel(254, 0);
        feed_pixel(255, 0); feed_pixel(0, 0);   feed_pixel(2, 0);   feed_pixel(3, 0);
        feed_pixel(128, 0); feed_pixel(127, 0); feed_pixel(255, 0); feed_pixel(0, 0);
        settle();

        // A source width of zero acts as a width of one: a single tall column.
        set_window(0, 0, 0, 1024, 1024);
        queue_image(4, 1);
        settle();

        // Empty windows, by height and then by width, give no results at all.
        set_window(3, 0, 0, 0, 3);
        queue_image(6, 0);
        settle();
        set_window(3, 0, 0, 2, 0);
        queue_image(6, 0);
        settle();

        // A window inside the image, so that pixels around it are dropped; the first image
        // is cut short by the start of the next.
        set_window(6, 1, 2, 2, 3);
        queue_image(15, 0);
        queue_image(18, 1);
        settle();

        // Random part: small images under random windows until the pixel budget is spent.
        // Most windows lie inside the image and most images are complete; the rest reach
        // past the image edge, are cut short or carry stray image starts.
        while (fed_total < ITEMS) begin
            sw = $urandom_range(1, 12);
            tp = $urandom_range(0, 3);
            lf = $urandom_range(0, sw - 1);
            ht = $urandom_range(1, 5);
            wd = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16)
                                             : $urandom_range(1, sw - lf);
            rows = tp + ht + $urandom_range(0, 1);
            set_window(sw, tp, lf, ht, wd);
            repeat ($urandom_range(1, 2)) begin
                n = sw * rows;
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, n);
                if (n > ITEMS - fed_total)
                    n = ITEMS - fed_total;
                style = $urandom_range(0, 7);
                queue_image(n, style < 5 ? 0 : (style < 7 ? 1 : 2));
            end
            settle();
        end

        $display("Run went through %0d window settings: %0d pixels inside a window, %0d dropped.",
                 settings_used, win_pixels, dropped);
        $display("%0d result beats were checked against the predicted enlarged image.",
                 beats_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
